[hdl/slx_pkg.sv]
// ---------------------------------------------------------------------------
// slx_pkg
// Shared types, token codes, character codes and keyword table for the
// script lexer.
// ---------------------------------------------------------------------------
package slx_pkg;

  localparam int QDEPTH = 4;

  typedef struct packed {
    logic [5:0]  kind;
    logic [1:0]  err;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
  } tok_t;

  // One queue entry: up to two tokens caused by one input beat
  typedef struct packed {
    logic two;
    tok_t t0;
    tok_t t1;
  } ent_t;

  localparam logic [5:0] K_LPAREN  = 6'd0;
  localparam logic [5:0] K_RPAREN  = 6'd1;
  localparam logic [5:0] K_LBRACE  = 6'd2;
  localparam logic [5:0] K_RBRACE  = 6'd3;
  localparam logic [5:0] K_SEMI    = 6'd4;
  localparam logic [5:0] K_COMMA   = 6'd5;
  localparam logic [5:0] K_MINUS   = 6'd6;
  localparam logic [5:0] K_PLUS    = 6'd7;
  localparam logic [5:0] K_SLASH   = 6'd8;
  localparam logic [5:0] K_STAR    = 6'd9;
  localparam logic [5:0] K_BANG    = 6'd10;
  localparam logic [5:0] K_EQUAL   = 6'd12;
  localparam logic [5:0] K_LESS    = 6'd14;
  localparam logic [5:0] K_GREATER = 6'd16;
  localparam logic [5:0] K_IDENT   = 6'd18;
  localparam logic [5:0] K_STRING  = 6'd19;
  localparam logic [5:0] K_NUMBER  = 6'd20;
  localparam logic [5:0] K_ERROR   = 6'd37;
  localparam logic [5:0] K_END     = 6'd38;

  localparam logic [1:0] E_NONE    = 2'd0;
  localparam logic [1:0] E_STRING  = 2'd1;
  localparam logic [1:0] E_NUMBER  = 2'd2;
  localparam logic [1:0] E_CHAR    = 2'd3;

  localparam logic [7:0] C_TAB    = 8'h09;
  localparam logic [7:0] C_LF     = 8'h0A;
  localparam logic [7:0] C_CR     = 8'h0D;
  localparam logic [7:0] C_SPACE  = 8'h20;
  localparam logic [7:0] C_BANG   = 8'h21;
  localparam logic [7:0] C_QUOTE  = 8'h22;
  localparam logic [7:0] C_HASH   = 8'h23;
  localparam logic [7:0] C_LPAREN = 8'h28;
  localparam logic [7:0] C_RPAREN = 8'h29;
  localparam logic [7:0] C_STAR   = 8'h2A;
  localparam logic [7:0] C_PLUS   = 8'h2B;
  localparam logic [7:0] C_COMMA  = 8'h2C;
  localparam logic [7:0] C_MINUS  = 8'h2D;
  localparam logic [7:0] C_DOT    = 8'h2E;
  localparam logic [7:0] C_SLASH  = 8'h2F;
  localparam logic [7:0] C_SEMI   = 8'h3B;
  localparam logic [7:0] C_LESS   = 8'h3C;
  localparam logic [7:0] C_EQUAL  = 8'h3D;
  localparam logic [7:0] C_GREAT  = 8'h3E;
  localparam logic [7:0] C_LBRACE = 8'h7B;
  localparam logic [7:0] C_RBRACE = 8'h7D;

  // Keyword text left-justified: first byte in bits [47:40]
  localparam logic [15:0][47:0] KW_TXT = '{
    48'("while")  << 8,  48'("var")    << 24, 48'("type")   << 16,
    48'("true")   << 16, 48'("return"),       48'("print")  << 8,
    48'("or")     << 32, 48'("nil")    << 24, 48'("if")     << 32,
    48'("for")    << 24, 48'("fn")     << 32, 48'("false")  << 8,
    48'("elif")   << 16, 48'("else")   << 16, 48'("const")  << 8,
    48'("and")    << 24
  };
  localparam logic [15:0][2:0] KW_LEN = '{
    3'd5, 3'd3, 3'd4, 3'd4, 3'd6, 3'd5, 3'd2, 3'd3,
    3'd2, 3'd3, 3'd2, 3'd5, 3'd4, 3'd4, 3'd5, 3'd3
  };

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Keyword kinds are 21 + table position
  function automatic logic [5:0] kw_kind(input logic [5:0][7:0] p,
                                         input logic [2:0] n,
                                         input logic fits);
    logic [5:0] k;
    logic       hit;
    k = K_IDENT;
    for (int i = 0; i < 16; i++) begin
      hit = fits && (n == KW_LEN[i]);
      for (int j = 0; j < 6; j++) begin
        if (j < int'(KW_LEN[i]) && p[j] != KW_TXT[i][47-8*j -: 8]) hit = 1'b0;
      end
      if (hit) k = 6'(21 + i);
    end
    return k;
  endfunction

endpackage

[hdl/script_lexer_top.sv]
// ---------------------------------------------------------------------------
// script_lexer_top
// Streaming tokenizer for a small scripting language.
// ---------------------------------------------------------------------------
// Takes one source byte per beat (or an end-of-source flag) and returns
// tokens with kind, error code, start offset, length and line number. The
// scanner handles one byte per cycle; a beat yields zero, one or two tokens,
// and the output side sends one token per cycle while the sink is ready, so
// the sustained input rate is one byte per cycle as long as tokens average at
// most one per byte. A four-entry token queue decouples the scanner from
// output stalls; input stalls only when that queue is full.
module script_lexer_top import slx_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tuser,   // [0] end_of_source
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [1:0] error_code, [17:2] token_start,
                                  // [33:18] token_length, [49:34] line_number
  output logic [5:0]  out_tuser,  // [5:0] token_kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic acc, push, pop, full, nempty;
  ent_t wr_ent, head;
  tok_t tok;

  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  slx_front #(.POSITION_BITS(POSITION_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .acc(acc), .ch(in_tdata), .eos(in_tuser),
    .cfg_we(cfg_valid && cfg_ready), .cfg_data(cfg_data),
    .push(push), .ent(wr_ent)
  );

  slx_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .wr_ent(wr_ent), .pop(pop),
    .full(full), .nempty(nempty), .head(head)
  );

  slx_back u_back (
    .clk(clk), .rst_n(rst_n), .nempty(nempty), .head(head), .pop(pop),
    .out_ready(out_tready), .out_valid(out_tvalid), .out_tok(tok),
    .out_last(out_tlast)
  );

  assign out_tuser = tok.kind;
  assign out_tdata = {6'b0, tok.line, tok.len, tok.start, tok.err};

endmodule

[hdl/slx_front.sv]
// ---------------------------------------------------------------------------
// slx_front
// Byte scanner: classifies each byte, tracks the token in progress and
// pushes the tokens that one beat finishes as one queue entry.
// ---------------------------------------------------------------------------
module slx_front import slx_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic [7:0]  ch,
  input  logic        eos,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  output logic        push,
  output ent_t        ent
);

  localparam int P = POSITION_BITS;

  typedef enum logic [2:0] {
    M_IDLE, M_COMMENT, M_IDENT, M_INT, M_DOT, M_FRAC, M_STRING, M_OP
  } mode_t;

  mode_t           mode_r, mode_nxt;
  logic [P-1:0]    off_r, off_nxt, beg_r, beg_nxt;
  logic [15:0]     line_r, line_nxt, limit_r;
  logic [5:0][7:0] kwp_r, kwp_nxt;
  logic [5:0]      pend_r, pend_nxt;
  logic [P-1:0]    len, len1;
  logic            scan, bump, e0, e1;
  tok_t            tk0, tk1;

  function automatic logic [15:0] w16(input logic [P-1:0] v);
    logic [P+15:0] x;
    x = {16'b0, v};
    return x[15:0];
  endfunction

  assign len  = off_r - beg_r;
  assign len1 = len + P'(1);

  always_comb begin
    mode_nxt = mode_r;
    beg_nxt  = beg_r;
    off_nxt  = off_r;
    kwp_nxt  = kwp_r;
    pend_nxt = pend_r;
    line_nxt = line_r;
    scan = 1'b0;
    bump = 1'b0;
    e0 = 1'b0;
    e1 = 1'b0;
    tk0 = '{kind: K_NUMBER, err: E_NONE, start: w16(beg_r), len: w16(len), line: line_r};
    tk1 = '{kind: K_END, err: E_NONE, start: w16(off_r), len: 16'd1, line: line_r};
    if (eos) begin
      case (mode_r)
        M_IDENT: begin
          e0 = 1'b1;
          tk0.kind = kw_kind(kwp_r, len[2:0], len <= P'(6));
        end
        M_INT, M_FRAC: e0 = 1'b1;
        M_DOT: begin
          e0 = 1'b1; tk0.kind = K_ERROR; tk0.err = E_NUMBER;
        end
        M_STRING: begin
          e0 = 1'b1; tk0.kind = K_ERROR; tk0.err = E_STRING;
        end
        M_OP: begin
          e0 = 1'b1; tk0.kind = pend_r;
        end
        default: ;
      endcase
      e1 = 1'b1;
      tk1.len = 16'd0;
      mode_nxt = M_IDLE;
    end else begin
      off_nxt = off_r + P'(1);
      case (mode_r)
        M_COMMENT: if (ch == C_LF) begin
          bump = 1'b1; mode_nxt = M_IDLE;
        end
        M_IDENT: begin
          if (is_alpha(ch) || is_digit(ch)) begin
            if (len < P'(6)) kwp_nxt[len[2:0]] = ch;
          end else begin
            e0 = 1'b1; scan = 1'b1;
            tk0.kind = kw_kind(kwp_r, len[2:0], len <= P'(6));
          end
        end
        M_INT: begin
          if (ch == C_DOT) mode_nxt = M_DOT;
          else if (!is_digit(ch)) begin
            e0 = 1'b1; scan = 1'b1;
          end
        end
        M_DOT: begin
          if (is_digit(ch)) mode_nxt = M_FRAC;
          else begin
            e0 = 1'b1; scan = 1'b1; tk0.kind = K_ERROR; tk0.err = E_NUMBER;
          end
        end
        M_FRAC: if (!is_digit(ch)) begin
          e0 = 1'b1; scan = 1'b1;
        end
        M_STRING: begin
          if (ch == C_QUOTE) begin
            e0 = 1'b1; tk0.kind = K_STRING; tk0.len = w16(len1); mode_nxt = M_IDLE;
          end else if (ch == C_LF) bump = 1'b1;
        end
        M_OP: begin
          e0 = 1'b1; tk0.kind = pend_r;
          if (ch == C_EQUAL) begin
            tk0.kind = pend_r + 6'd1; tk0.len = w16(len1); mode_nxt = M_IDLE;
          end else scan = 1'b1;
        end
        default: scan = 1'b1;
      endcase
      // Scan the byte afresh from between tokens
      if (scan) begin
        mode_nxt = M_IDLE;
        if (is_alpha(ch)) begin
          mode_nxt = M_IDENT; beg_nxt = off_r; kwp_nxt[0] = ch;
        end else if (is_digit(ch)) begin
          mode_nxt = M_INT; beg_nxt = off_r;
        end else begin
          e1 = 1'b1;
          case (ch)
            C_SPACE, C_CR, C_TAB: e1 = 1'b0;
            C_LF: begin
              e1 = 1'b0; bump = 1'b1;
            end
            C_HASH: begin
              e1 = 1'b0; mode_nxt = M_COMMENT;
            end
            C_QUOTE: begin
              e1 = 1'b0; mode_nxt = M_STRING; beg_nxt = off_r;
            end
            C_BANG, C_EQUAL, C_LESS, C_GREAT: begin
              e1 = 1'b0; mode_nxt = M_OP; beg_nxt = off_r;
              pend_nxt = (ch == C_BANG) ? K_BANG : (ch == C_EQUAL) ? K_EQUAL :
                         (ch == C_LESS) ? K_LESS : K_GREATER;
            end
            C_LPAREN: tk1.kind = K_LPAREN;
            C_RPAREN: tk1.kind = K_RPAREN;
            C_LBRACE: tk1.kind = K_LBRACE;
            C_RBRACE: tk1.kind = K_RBRACE;
            C_SEMI:   tk1.kind = K_SEMI;
            C_COMMA:  tk1.kind = K_COMMA;
            C_MINUS:  tk1.kind = K_MINUS;
            C_PLUS:   tk1.kind = K_PLUS;
            C_SLASH:  tk1.kind = K_SLASH;
            C_STAR:   tk1.kind = K_STAR;
            default: begin
              tk1.kind = K_ERROR; tk1.err = E_CHAR;
            end
          endcase
        end
      end
    end
    if (bump && line_r < limit_r) line_nxt = line_r + 16'd1;
  end

  assign push    = acc && (e0 || e1);
  assign ent.two = e0 && e1;
  assign ent.t0  = e0 ? tk0 : tk1;
  assign ent.t1  = tk1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      off_r   <= '0;
      beg_r   <= '0;
      line_r  <= 16'd1;
      limit_r <= 16'hFFFF;
    end else begin
      if (cfg_we) limit_r <= cfg_data;
      if (acc) begin
        mode_r <= mode_nxt;
        off_r  <= off_nxt;
        beg_r  <= beg_nxt;
        line_r <= line_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      kwp_r  <= kwp_nxt;
      pend_r <= pend_nxt;
    end
  end

  a_eos_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && eos) |=> (mode_r == M_IDLE))
    else $error("scanner not idle after end of source");
  a_line_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (line_r != 16'd0))
    else $error("line counter reached zero");

endmodule

[hdl/slx_queue.sv]
// ---------------------------------------------------------------------------
// slx_queue
// Short FIFO of token entries between the scanner and the output side.
// ---------------------------------------------------------------------------
module slx_queue import slx_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  ent_t wr_ent,
  input  logic pop,
  output logic full,
  output logic nempty,
  output ent_t head
);

  localparam int AW = $clog2(QDEPTH);

  ent_t          mem_r [QDEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full   = (cnt_r == (AW+1)'(QDEPTH));
  assign nempty = (cnt_r != '0);
  assign head   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + AW'(1);
      if (pop)  rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_ent;
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> !full)
    else $error("token queue overrun");

endmodule

[hdl/slx_back.sv]
// ---------------------------------------------------------------------------
// slx_back
// Output side: splits each queue entry into single token beats and holds
// them in an output register.
// ---------------------------------------------------------------------------
module slx_back import slx_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic nempty,
  input  ent_t head,
  output logic pop,
  input  logic out_ready,
  output logic out_valid,
  output tok_t out_tok,
  output logic out_last
);

  logic sel_r, ov_r, load;

  assign out_valid = ov_r;
  assign load = nempty && (!ov_r || out_ready);
  assign pop  = load && (!head.two || sel_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      sel_r <= 1'b0;
    end else begin
      if (load) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      if (load) sel_r <= head.two && !sel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tok  <= sel_r ? head.t1 : head.t0;
      out_last <= !head.two || sel_r;
    end
  end

  a_sel_two: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> (nempty && head.two))
    else $error("second token selected without a two-token entry");

endmodule

[tb/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the script lexer: a token predictor follows every
// accepted source byte, and a scoreboard compares each token beat in order.
// ---------------------------------------------------------------------------
module tb_top;
  import slx_pkg::*;

  localparam int LIMIT_CYCLES = 400000;

  typedef enum logic [3:0] {
    SM_IDLE, SM_COMMENT, SM_IDENT, SM_INT, SM_DOT, SM_FRAC, SM_STRING, SM_OP
  } scan_e;

  // Token queue and predictor state in one class
  class token_scoreboard;
    tok_t        exp_q[$];
    bit          last_q[$];
    int          errors;
    int          tokens;
    logic [15:0] limit;
    scan_e       mode;
    logic [15:0] offset;
    logic [15:0] tbegin;
    logic [15:0] line;
    logic [5:0][7:0] prefix;
    logic [7:0]  op_ch;

    function new();
      limit = 16'hFFFF;
      mode = SM_IDLE;
      offset = '0;
      tbegin = '0;
      line = 16'd1;
      prefix = '0;
      op_ch = '0;
      errors = 0;
      tokens = 0;
    endfunction

    function void bump();
      if (line < limit) line = line + 16'd1;
    endfunction

    function void push(logic [5:0] k, logic [1:0] e, logic [15:0] s, logic [15:0] n);
      tok_t t;
      t.kind = k; t.err = e; t.start = s; t.len = n; t.line = line;
      exp_q.push_back(t);
      last_q.push_back(1'b0);
    endfunction

    function logic [5:0] word_kind(logic [15:0] n);
      string kw[16];
      logic [5:0] k;
      bit hit;
      kw = '{"and", "const", "else", "elif", "false", "fn", "for", "if", "nil", "or",
             "print", "return", "true", "type", "var", "while"};
      k = K_IDENT;
      for (int i = 0; i < 16; i++) begin
        if (n == kw[i].len()) begin
          hit = 1;
          for (int j = 0; j < kw[i].len(); j++)
            if (prefix[j] != kw[i][j]) hit = 0;
          if (hit) k = 6'(21 + i);
        end
      end
      return k;
    endfunction

    function logic [5:0] op_kind();
      case (op_ch)
        C_BANG:  return K_BANG;
        C_EQUAL: return K_EQUAL;
        C_LESS:  return K_LESS;
        default: return K_GREATER;
      endcase
    endfunction

    function void fresh(logic [7:0] c);
      mode = SM_IDLE;
      if (is_alpha_c(c)) begin
        mode = SM_IDENT; tbegin = offset; prefix[0] = c;
      end else if (c >= "0" && c <= "9") begin
        mode = SM_INT; tbegin = offset;
      end else begin
        case (c)
          C_SPACE, C_CR, C_TAB: ;
          C_LF: bump();
          C_HASH: mode = SM_COMMENT;
          C_QUOTE: begin mode = SM_STRING; tbegin = offset; end
          C_BANG, C_EQUAL, C_LESS, C_GREAT: begin
            mode = SM_OP; tbegin = offset; op_ch = c;
          end
          C_LPAREN: push(K_LPAREN, E_NONE, offset, 16'd1);
          C_RPAREN: push(K_RPAREN, E_NONE, offset, 16'd1);
          C_LBRACE: push(K_LBRACE, E_NONE, offset, 16'd1);
          C_RBRACE: push(K_RBRACE, E_NONE, offset, 16'd1);
          C_SEMI:   push(K_SEMI, E_NONE, offset, 16'd1);
          C_COMMA:  push(K_COMMA, E_NONE, offset, 16'd1);
          C_MINUS:  push(K_MINUS, E_NONE, offset, 16'd1);
          C_PLUS:   push(K_PLUS, E_NONE, offset, 16'd1);
          C_SLASH:  push(K_SLASH, E_NONE, offset, 16'd1);
          C_STAR:   push(K_STAR, E_NONE, offset, 16'd1);
          default:  push(K_ERROR, E_CHAR, offset, 16'd1);
        endcase
      end
    endfunction

    function bit is_alpha_c(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    // Note one accepted source beat and queue the tokens it finishes
    function void note_byte(logic [7:0] c, bit eos);
      logic [15:0] n;
      bit dig;
      int n_prev;
      n_prev = exp_q.size();
      n = offset - tbegin;
      dig = (c >= "0" && c <= "9");
      if (eos) begin
        case (mode)
          SM_IDENT: push(word_kind(n), E_NONE, tbegin, n);
          SM_INT, SM_FRAC: push(K_NUMBER, E_NONE, tbegin, n);
          SM_DOT: push(K_ERROR, E_NUMBER, tbegin, n);
          SM_STRING: push(K_ERROR, E_STRING, tbegin, n);
          SM_OP: push(op_kind(), E_NONE, tbegin, n);
          default: ;
        endcase
        push(K_END, E_NONE, offset, 16'd0);
        mode = SM_IDLE;
        last_q[$] = 1'b1;
        return;
      end
      case (mode)
        SM_COMMENT: if (c == C_LF) begin bump(); mode = SM_IDLE; end
        SM_IDENT:
          if (is_alpha_c(c) || dig) begin
            if (n < 6) prefix[n] = c;
          end else begin
            push(word_kind(n), E_NONE, tbegin, n); fresh(c);
          end
        SM_INT:
          if (c == C_DOT) mode = SM_DOT;
          else if (!dig) begin push(K_NUMBER, E_NONE, tbegin, n); fresh(c); end
        SM_DOT:
          if (dig) mode = SM_FRAC;
          else begin push(K_ERROR, E_NUMBER, tbegin, n); fresh(c); end
        SM_FRAC:
          if (!dig) begin push(K_NUMBER, E_NONE, tbegin, n); fresh(c); end
        SM_STRING:
          if (c == C_QUOTE) begin
            push(K_STRING, E_NONE, tbegin, n + 16'd1); mode = SM_IDLE;
          end else if (c == C_LF) bump();
        SM_OP:
          if (c == C_EQUAL) begin
            push(op_kind() + 6'd1, E_NONE, tbegin, n + 16'd1); mode = SM_IDLE;
          end else begin
            push(op_kind(), E_NONE, tbegin, n); fresh(c);
          end
        default: fresh(c);
      endcase
      offset = offset + 16'd1;
      if (exp_q.size() > n_prev) last_q[$] = 1'b1;
    endfunction

    function void check_token(tok_t got, bit got_last);
      tok_t e;
      bit el;
      tokens++;
      if (exp_q.size() == 0) begin
        $error("unexpected token kind=%0d start=%0d", got.kind, got.start);
        errors++;
        return;
      end
      e = exp_q.pop_front();
      el = last_q.pop_front();
      if (got.kind !== e.kind) begin
        $error("token_kind expected %0d got %0d", e.kind, got.kind); errors++;
      end
      if (got.err !== e.err) begin
        $error("error_code expected %0d got %0d", e.err, got.err); errors++;
      end
      if (got.start !== e.start) begin
        $error("token_start expected %0d got %0d", e.start, got.start); errors++;
      end
      if (got.len !== e.len) begin
        $error("token_length expected %0d got %0d", e.len, got.len); errors++;
      end
      if (got.line !== e.line) begin
        $error("line_number expected %0d got %0d", e.line, got.line); errors++;
      end
      if (got_last !== el) begin
        $error("last expected %0d got %0d", el, got_last); errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [5:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  token_scoreboard sb = new();
  int  cycles = 0;
  int  sent = 0;
  bit  sink_stall_off = 0;
  bit  src_gaps = 1;

  always #5 clk = ~clk;

  script_lexer_top #(.POSITION_BITS(16)) u_dut (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Sink: random ready unless stalls are off, check every accepted token beat
  always @(posedge clk) begin
    tok_t t;
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      t.kind = out_tuser;
      t.err = out_tdata[1:0];
      t.start = out_tdata[17:2];
      t.len = out_tdata[33:18];
      t.line = out_tdata[49:34];
      sb.check_token(t, out_tlast);
    end
    out_tready <= sink_stall_off ? 1'b1 : ($urandom_range(0, 9) < 7);
  end

  // Valid stays high after an accepted beat; drop it only for a gap or a drain
  task automatic send_beat(logic [7:0] c, bit eos);
    int g;
    g = src_gaps ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tuser <= eos;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(c, eos);
    sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 0);
  endtask

  task automatic drain();
    int w;
    w = 0;
    in_tvalid <= 1'b0;
    while (sb.exp_q.size() != 0 && w < 20000) begin
      @(posedge clk); w++;
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(logic [15:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.limit = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic string pick_word();
    string w[20];
    w = '{"and", "const", "else", "elif", "false", "fn", "for", "if", "nil", "or",
          "print", "return", "true", "type", "var", "while", "fo", "x_1",
          "returns", "Fn"};
    return w[$urandom_range(0, 19)];
  endfunction

  // Fragments with random content, some of them malformed, plus raw noise
  task automatic send_fragment();
    string ops[14];
    ops = '{"(", ")", "{", "}", ";", ",", "-", "+", "/", "*", "!=", "==", "<=", ">"};
    case ($urandom_range(0, 11))
      0, 1: send_text(pick_word());
      2: begin
        send_beat(8'($urandom_range("0", "9")), 0);
        if ($urandom_range(0, 1)) send_text(".");
        if ($urandom_range(0, 2) != 0) send_beat(8'($urandom_range("0", "9")), 0);
      end
      3: begin
        send_text("\"");
        repeat ($urandom_range(0, 6)) send_beat(8'($urandom_range(32, 126)) == C_QUOTE ?
                                                C_LF : 8'($urandom_range(32, 126)), 0);
        if ($urandom_range(0, 5) != 0) send_text("\"");
      end
      4, 5: send_text(ops[$urandom_range(0, 13)]);
      6: send_text("# note\n");
      7: send_beat(C_LF, 0);
      8: send_beat(8'($urandom_range(0, 255)), 0);
      9: if ($urandom_range(0, 7) == 0) send_beat(8'($urandom), 1);
      default: send_beat(C_SPACE, 0);
    endcase
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: keywords, operators, numbers, strings, errors, END flushes
    send_text("for fn if x and const else elif false nil or print return\n");
    send_text("true type var while_ 1.5 12. x\"ab\n\"#c\n");
    send_text("(){};,-+/*! != = == < <= > >= . @");
    send_beat(8'h00, 0); send_beat(8'hFF, 0); send_beat(8'h80, 0);
    send_text("\"open"); send_beat(8'h00, 1);
    send_text("7."); send_beat(8'h00, 1);
    send_text("<"); send_beat(8'hFF, 1);

    write_limit(16'd1);
    send_text("a\nb\n\"\n\"c"); send_beat(8'h00, 1);
    write_limit(16'd3);

    for (int n = 0; n < 150; n++) send_fragment();
    drain();
    // Hold the source until every token is out
    write_limit(16'd65535);
    for (int n = 0; n < 150; n++) send_fragment();
    write_limit(16'd5);
    src_gaps = 0;
    sink_stall_off = 1;
    for (int n = 0; n < 75; n++) send_fragment();
    src_gaps = 1;
    sink_stall_off = 0;
    send_beat(8'h00, 1);
    drain();

    $display("Sent %0d source beats, checked %0d tokens over line limits 1, 3, 5, 65535.",
             sent, sb.tokens);
    if (sb.errors == 0 && sb.exp_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
